@@ rtl/rmslm_pkg.sv @@
// Shared types and constants for the RMS level meter.
// Used by the channel interfaces, controller, datapath, top level and checker.
`default_nettype none

package rmslm_pkg;

   localparam int unsigned BLOCK_SAMPLES_DEF = 256;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned LEVEL_W     = 16;
   localparam int unsigned GAIN_W      = 16;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   // one Q30 square needs 31 bits; the block sum grows by log2 of the block length
   localparam int unsigned SQ_W       = 31;
   localparam int unsigned RAD_W      = 32;
   localparam int unsigned ROOT_STEPS = RAD_W / 2;

   localparam logic [LEVEL_W-1:0] Q15_ONE        = 16'h8000;
   localparam logic [GAIN_W-1:0]  GAIN_RESET     = 16'h8000;
   localparam logic [15:0]        RELEASE_Q15    = 16'd3277;
   localparam logic [15:0]        POLL_DECAY_Q15 = 16'd31130;
   localparam logic [32:0]        ROUND_Q15      = 33'd16384;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ATTEN_GAIN = 1'b0,
      CSR_MIC_ENABLE = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_POLL   = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIV,
      ST_ROOT,
      ST_MUL,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic scale;
      logic square;
      logic accum;
      logic div_step;
      logic div_last;
      logic root_step;
      logic mul;
      logic update;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic mic_en;
      logic block_end;
      logic poll;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ rtl/rmslm_req_if.sv @@
// Sample/poll request channel: valid/ready handshake plus request payload.
// Depends on rmslm_pkg for field widths.
`default_nettype none

interface rmslm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic signed [rmslm_pkg::SAMPLE_W-1:0] sample;
   logic                                last;

   modport source (output valid, output operation, output sample, output last, input ready);
   modport sink   (input valid, input operation, input sample, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/rmslm_rsp_if.sv @@
// Level result channel: valid/ready handshake plus the Q15 level.
// Depends on rmslm_pkg for field widths.
`default_nettype none

interface rmslm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rmslm_pkg::LEVEL_W-1:0]    level;

   modport source (output valid, output level, input ready);
   modport sink   (input valid, input level, output ready);
endinterface

`default_nettype wire

@@ rtl/rmslm_ctrl.sv @@
// Controller FSM for the RMS level meter: sequences scale, square, accumulate,
// serial divide, serial square root, smoothing and result hand-off. Uses rmslm_pkg.
`default_nettype none

module rmslm_ctrl #(
   parameter int unsigned BLOCK_SAMPLES = rmslm_pkg::BLOCK_SAMPLES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  rmslm_pkg::op_type        req_op,
   input  logic                     req_last,
   output logic                     req_ready,
   input  rmslm_pkg::dp_stat_type   stat,
   output rmslm_pkg::dp_cmd_type    cmd
);

   localparam int unsigned SUM_W  = rmslm_pkg::SQ_W + $clog2(BLOCK_SAMPLES);
   localparam int unsigned STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(rmslm_pkg::ROOT_STEPS - 1);

   rmslm_pkg::state_type state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmslm_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      case (state_ff)
         rmslm_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (!stat.mic_en) begin
                  if (req_op == rmslm_pkg::OP_POLL || req_last) begin
                     state_in = rmslm_pkg::ST_EMIT;
                  end
               end else if (req_op == rmslm_pkg::OP_POLL) begin
                  state_in = rmslm_pkg::ST_MUL;
               end else begin
                  state_in = rmslm_pkg::ST_SCALE;
               end
            end
         end
         rmslm_pkg::ST_SCALE:  state_in = rmslm_pkg::ST_SQUARE;
         rmslm_pkg::ST_SQUARE: state_in = rmslm_pkg::ST_ACCUM;
         rmslm_pkg::ST_ACCUM: begin
            state_in = stat.block_end ? rmslm_pkg::ST_DIV : rmslm_pkg::ST_IDLE;
         end
         rmslm_pkg::ST_DIV: begin
            if (step_ff == DIV_LAST) begin
               state_in = rmslm_pkg::ST_ROOT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         rmslm_pkg::ST_ROOT: begin
            if (step_ff == ROOT_LAST) begin
               state_in = rmslm_pkg::ST_MUL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         rmslm_pkg::ST_MUL: begin
            state_in = stat.poll ? rmslm_pkg::ST_EMIT : rmslm_pkg::ST_UPDATE;
         end
         rmslm_pkg::ST_UPDATE: state_in = rmslm_pkg::ST_EMIT;
         rmslm_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               state_in = rmslm_pkg::ST_IDLE;
            end
         end
         default: state_in = rmslm_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rmslm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         rmslm_pkg::ST_SCALE:  cmd.scale  = 1'b1;
         rmslm_pkg::ST_SQUARE: cmd.square = 1'b1;
         rmslm_pkg::ST_ACCUM:  cmd.accum  = 1'b1;
         rmslm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_last = (step_ff == DIV_LAST);
         end
         rmslm_pkg::ST_ROOT:   cmd.root_step = 1'b1;
         rmslm_pkg::ST_MUL:    cmd.mul       = 1'b1;
         rmslm_pkg::ST_UPDATE: cmd.update    = 1'b1;
         rmslm_pkg::ST_EMIT:   cmd.emit      = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/rmslm_dpath.sv @@
// Datapath for the RMS level meter: config registers, sample scaling and squaring,
// block sum, restoring divider, digit-by-digit square root, smoothing, output register.
// Uses rmslm_pkg; driven by rmslm_ctrl.
`default_nettype none

module rmslm_dpath #(
   parameter int unsigned BLOCK_SAMPLES = rmslm_pkg::BLOCK_SAMPLES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rmslm_pkg::dp_cmd_type                  cmd,
   output rmslm_pkg::dp_stat_type                 stat,
   input  logic                                   csr_we,
   input  logic [rmslm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rmslm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  rmslm_pkg::op_type                      req_op,
   input  logic signed [rmslm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                   req_last,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [rmslm_pkg::LEVEL_W-1:0]          rsp_level
);

   localparam int unsigned SUM_W  = rmslm_pkg::SQ_W + $clog2(BLOCK_SAMPLES);
   localparam int unsigned CNT_W  = $clog2(BLOCK_SAMPLES + 1);
   localparam int unsigned LW     = rmslm_pkg::LEVEL_W;
   localparam int unsigned RAD_W  = rmslm_pkg::RAD_W;
   localparam logic [RAD_W-1:0] ROOT_BIT0 = RAD_W'(1) << (RAD_W - 2);

   // config and metering state
   logic [rmslm_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic                         mic_en_ff, mic_en_in;
   logic [LW-1:0]                level_ff, level_in;
   logic [SUM_W-1:0]             sum_ff, sum_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // working registers
   rmslm_pkg::op_type            op_ff, op_in;
   logic                         last_ff, last_in;
   logic [rmslm_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [LW-1:0]                scaled_ff, scaled_in;
   logic [rmslm_pkg::SQ_W-1:0]   sq_ff, sq_in;
   logic [SUM_W-1:0]             quo_ff, quo_in;
   logic [CNT_W-1:0]             rem_ff, rem_in;
   logic [RAD_W-1:0]             rad_ff, rad_in;
   logic [RAD_W-1:0]             res_ff, res_in;
   logic [RAD_W-1:0]             bit_ff, bit_in;
   logic [31:0]                  prod_ff, prod_in;
   logic [LW-1:0]                rsp_level_ff, rsp_level_in;

   logic                         csr_clear;
   logic [15:0]                  mag;
   logic [31:0]                  scale_prod;
   logic [32:0]                  scale_round;
   logic [17:0]                  scale_shift;
   logic [31:0]                  sq_full;
   logic [SUM_W-1:0]             sum_acc;
   logic [CNT_W-1:0]             count_inc;
   logic [CNT_W:0]               div_trial;
   logic [CNT_W:0]               div_diff;
   logic                         div_fits;
   logic [CNT_W-1:0]             rem_next;
   logic [SUM_W-1:0]             quo_next;
   logic [RAD_W-1:0]             root_trial;
   logic                         root_ge;
   logic [LW-1:0]                rms;
   logic [15:0]                  mul_a;
   logic [15:0]                  mul_b;
   logic [32:0]                  prod_round;
   logic [LW-1:0]                prod_q15;
   logic [LW:0]                  attack_sum;
   logic [LW-1:0]                level_upd;
   logic [LW-1:0]                out_val;

   // ---------------- arithmetic ----------------
   always_comb begin
      mag         = sample_ff[15] ? (16'h0000 - sample_ff) : sample_ff;
      scale_prod  = mag * gain_ff;
      scale_round = {1'b0, scale_prod} + rmslm_pkg::ROUND_Q15;
      scale_shift = scale_round[32:15];
      scaled_in   = (scale_shift > 18'(rmslm_pkg::Q15_ONE)) ? rmslm_pkg::Q15_ONE
                                                             : scale_shift[LW-1:0];
      sq_full     = scaled_ff * scaled_ff;
      sq_in       = sq_full[rmslm_pkg::SQ_W-1:0];
      sum_acc     = sum_ff + SUM_W'(sq_ff);
      count_inc   = count_ff + 1'b1;

      // restoring divide, one quotient bit per step
      div_trial = {rem_ff, quo_ff[SUM_W-1]};
      div_fits  = (div_trial >= {1'b0, count_ff});
      div_diff  = div_trial - {1'b0, count_ff};
      rem_next  = div_fits ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
      quo_next  = {quo_ff[SUM_W-2:0], div_fits};

      // square root, two radicand bits per step
      root_trial = res_ff + bit_ff;
      root_ge    = (rad_ff >= root_trial);
      rms        = (res_ff > RAD_W'(rmslm_pkg::Q15_ONE)) ? rmslm_pkg::Q15_ONE
                                                         : res_ff[LW-1:0];

      // one shared multiplier: release step or poll decay
      if (op_ff == rmslm_pkg::OP_POLL) begin
         mul_a = level_ff;
         mul_b = rmslm_pkg::POLL_DECAY_Q15;
      end else begin
         mul_a = level_ff - rms;
         mul_b = rmslm_pkg::RELEASE_Q15;
      end
      prod_in    = mul_a * mul_b;
      prod_round = {1'b0, prod_ff} + rmslm_pkg::ROUND_Q15;
      prod_q15   = prod_round[30:15];

      attack_sum = {1'b0, rms} - {1'b0, level_ff} + 1'b1;
      level_upd  = (rms > level_ff) ? (level_ff + attack_sum[LW:1]) : (level_ff - prod_q15);

      if (!mic_en_ff) begin
         out_val = '0;
      end else if (op_ff == rmslm_pkg::OP_POLL) begin
         out_val = prod_q15;
      end else begin
         out_val = level_ff;
      end
   end

   // ---------------- next values ----------------
   always_comb begin
      csr_clear = csr_we && (csr_index == rmslm_pkg::CSR_MIC_ENABLE) && !csr_wdata[0];

      gain_in  = gain_ff;
      mic_en_in = mic_en_ff;
      if (csr_we) begin
         case (rmslm_pkg::csr_index_type'(csr_index))
            rmslm_pkg::CSR_ATTEN_GAIN: gain_in   = csr_wdata[rmslm_pkg::GAIN_W-1:0];
            rmslm_pkg::CSR_MIC_ENABLE: mic_en_in = csr_wdata[0];
            default: gain_in = gain_ff;
         endcase
      end

      level_in = level_ff;
      sum_in   = sum_ff;
      count_in = count_ff;
      if (csr_clear || (cmd.load && !mic_en_ff)) begin
         level_in = '0;
         sum_in   = '0;
         count_in = '0;
      end else if (cmd.accum) begin
         sum_in   = sum_acc;
         count_in = count_inc;
      end else if (cmd.update) begin
         level_in = level_upd;
         sum_in   = '0;
         count_in = '0;
      end

      op_in     = cmd.load ? req_op : op_ff;
      last_in   = cmd.load ? req_last : last_ff;
      sample_in = cmd.load ? req_sample : sample_ff;

      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.accum) begin
         quo_in = sum_acc;
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = quo_next;
         rem_in = rem_next;
      end

      rad_in = rad_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (cmd.div_last) begin
         rad_in = RAD_W'(quo_next);
         res_in = '0;
         bit_in = ROOT_BIT0;
      end else if (cmd.root_step) begin
         rad_in = root_ge ? (rad_ff - root_trial) : rad_ff;
         res_in = root_ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
         bit_in = bit_ff >> 2;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = out_val;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= rmslm_pkg::GAIN_RESET;
         mic_en_ff    <= 1'b1;
         level_ff     <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff      <= gain_in;
         mic_en_ff    <= mic_en_in;
         level_ff     <= level_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      last_ff      <= last_in;
      sample_ff    <= sample_in;
      scaled_ff    <= cmd.scale ? scaled_in : scaled_ff;
      sq_ff        <= cmd.square ? sq_in : sq_ff;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      rad_ff       <= rad_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      prod_ff      <= cmd.mul ? prod_in : prod_ff;
      rsp_level_ff <= rsp_level_in;
   end

   assign stat.mic_en    = mic_en_ff;
   assign stat.block_end = last_ff || (count_inc == CNT_W'(BLOCK_SAMPLES));
   assign stat.poll      = (op_ff == rmslm_pkg::OP_POLL);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

endmodule

`default_nettype wire

@@ rtl/rms_level_meter_attack_decay.sv @@
// RMS level meter with fast attack and slow release, Q15 fixed point. A sample
// transaction steps through accept, scale by the gain, square and accumulate. The
// sample that closes a block then runs a restoring divider of the block sum by the
// count, one quotient bit per cycle, a square root at two radicand bits per cycle,
// a multiply, an update and a hand-off to the output register, which waits while
// that register still holds an untaken result. A poll runs accept, multiply and
// hand-off; with the microphone disabled only the accept runs, plus the hand-off
// for a poll or a block-closing sample. One transaction is in work at a time; the
// result sits in an output register, so the next request is taken while it waits.
// Depends on rmslm_pkg, rmslm_req_if, rmslm_rsp_if, rmslm_ctrl and rmslm_dpath.
`default_nettype none

module rms_level_meter_attack_decay #(
   parameter int unsigned BLOCK_SAMPLES = rmslm_pkg::BLOCK_SAMPLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   rmslm_req_if.sink                           req_ch,
   rmslm_rsp_if.source                         rsp_ch,
   input  logic                                csr_we,
   input  logic [rmslm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rmslm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rmslm_pkg::dp_cmd_type  cmd;
   rmslm_pkg::dp_stat_type stat;
   rmslm_pkg::op_type      req_op;

   assign req_op = rmslm_pkg::op_type'(req_ch.operation);

   rmslm_ctrl #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_op),
      .req_last  (req_ch.last),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rmslm_dpath #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_op     (req_op),
      .req_sample (req_ch.sample),
      .req_last   (req_ch.last),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_level  (rsp_ch.level)
   );

endmodule

`default_nettype wire

@@ rtl/rmslm_checker.sv @@
// Port-level checks for rms_level_meter_attack_decay, attached with bind.
// Depends on rmslm_pkg and the top level's channel interfaces.
`default_nettype none

module rmslm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [rmslm_pkg::LEVEL_W-1:0]  rsp_level
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level))
      else $error("rsp transaction changed while stalled");

   // level never exceeds Q15 full scale
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_level <= rmslm_pkg::Q15_ONE)
      else $error("rsp level above full scale");

   // no result can appear in the cycle right after a request is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early after request");

   // reset leaves the block idle with no pending result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind rms_level_meter_attack_decay rmslm_checker u_rmslm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_level (rsp_ch.level)
);

`default_nettype wire

@@ bench/tb_rms_level_meter_attack_decay.sv @@
// Self-checking bench for the RMS level meter: drives sample and poll transactions,
// predicts every smoothed level in a scoreboard class and compares the results.
// Depends on rmslm_pkg, rmslm_req_if, rmslm_rsp_if and rms_level_meter_attack_decay.
`timescale 1ns / 100ps

module tb_rms_level_meter_attack_decay;

   localparam int unsigned BLOCK_LEN     = rmslm_pkg::BLOCK_SAMPLES_DEF;
   localparam int unsigned RESET_CYCLES  = 10;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned IDLE_LIMIT    = 3000;
   localparam int unsigned PHASE_ITEMS   = 140;
   localparam int unsigned NUM_PHASES    = 8;

   class level_tracker;
      logic [rmslm_pkg::GAIN_W-1:0]  gain;
      logic                          mic_on;
      logic [rmslm_pkg::LEVEL_W-1:0] level;
      logic [38:0]                   square_acc;
      logic [8:0]                    sample_cnt;
      logic [rmslm_pkg::LEVEL_W-1:0] pending_levels[$];
      int unsigned                   error_count;

      function new();
         gain        = rmslm_pkg::GAIN_RESET;
         mic_on      = 1'b1;
         level       = '0;
         square_acc  = '0;
         sample_cnt  = '0;
         error_count = 0;
      endfunction

      function void write_register(rmslm_pkg::csr_index_type idx,
                                   logic [rmslm_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            rmslm_pkg::CSR_ATTEN_GAIN: gain = data[rmslm_pkg::GAIN_W-1:0];
            rmslm_pkg::CSR_MIC_ENABLE: begin
               mic_on = data[0];
               if (!mic_on) begin
                  level      = '0;
                  square_acc = '0;
                  sample_cnt = '0;
               end
            end
            default: gain = gain;
         endcase
      endfunction

      function void take_request(rmslm_pkg::op_type op,
                                 logic signed [rmslm_pkg::SAMPLE_W-1:0] smp,
                                 logic is_last);
         logic [16:0] mag;
         logic [33:0] scaled_full;
         logic [18:0] scaled;
         logic [63:0] mean;
         logic [63:0] root;
         logic [63:0] trial;
         logic [31:0] decayed;
         if (!mic_on) begin
            level      = '0;
            square_acc = '0;
            sample_cnt = '0;
            if (op == rmslm_pkg::OP_POLL || is_last)
               pending_levels.push_back('0);
            return;
         end
         if (op == rmslm_pkg::OP_POLL) begin
            decayed = (32'(level) * 32'(rmslm_pkg::POLL_DECAY_Q15) + 32'd16384) >> 15;
            pending_levels.push_back(decayed[rmslm_pkg::LEVEL_W-1:0]);
            return;
         end
         mag = smp[rmslm_pkg::SAMPLE_W-1] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
         scaled_full = 34'(mag) * 34'(gain) + 34'd16384;
         scaled = scaled_full[33:15];
         if (scaled > 19'(rmslm_pkg::Q15_ONE))
            scaled = 19'(rmslm_pkg::Q15_ONE);
         square_acc = square_acc + 39'(scaled) * 39'(scaled);
         sample_cnt = sample_cnt + 9'd1;
         if (!is_last && sample_cnt < BLOCK_LEN)
            return;
         mean = 64'(square_acc) / 64'(sample_cnt);
         // floor square root, one result bit at a time from the top
         root = '0;
         for (int b = 19; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= mean)
               root = trial;
         end
         if (root > 64'(rmslm_pkg::Q15_ONE))
            root = 64'(rmslm_pkg::Q15_ONE);
         if (root > 64'(level))
            level = level + 16'((root - 64'(level) + 64'd1) >> 1);
         else
            level = level - 16'(((64'(level) - root) * 64'(rmslm_pkg::RELEASE_Q15)
                                 + 64'd16384) >> 15);
         square_acc = '0;
         sample_cnt = '0;
         pending_levels.push_back(level);
      endfunction

      function void check_level(logic [rmslm_pkg::LEVEL_W-1:0] got);
         logic [rmslm_pkg::LEVEL_W-1:0] want;
         if (pending_levels.size() == 0) begin
            $error("level: expected none, actual %0d", got);
            error_count++;
            return;
         end
         want = pending_levels.pop_front();
         if (got !== want) begin
            $error("level: expected %0d, actual %0d", want, got);
            error_count++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [rmslm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rmslm_pkg::CSR_DATA_W-1:0]  csr_wdata;

   rmslm_req_if req_bus ();
   rmslm_rsp_if rsp_bus ();

   level_tracker meter;
   int unsigned  levels_seen = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  burst_left  = 0;

   rms_level_meter_attack_decay u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result checking and the no-progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            meter.check_level(rsp_bus.level);
            levels_seen++;
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_rms_level_meter_attack_decay: errors");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      int unsigned mode;
      int unsigned span;
      int unsigned tick;
      bit          held;
      rsp_bus.ready = 1'b0;
      held = 1'b0;
      tick = 0;
      repeat (RESET_CYCLES + 1) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(negedge clock);
            tick++;
            if (!held && levels_seen >= 40) begin
               // long hold so the meter fills up and stalls its request side
               rsp_bus.ready <= 1'b0;
               held = 1'b1;
               repeat (HOLD_CYCLES) @(negedge clock);
            end else begin
               case (mode)
                  0:       rsp_bus.ready <= 1'b1;
                  1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
                  2:       rsp_bus.ready <= (tick % 4 == 0);
                  default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
               endcase
            end
         end
      end
   end

   task automatic send_item(rmslm_pkg::op_type op,
                            logic signed [rmslm_pkg::SAMPLE_W-1:0] smp,
                            logic is_last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 10);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
      end
      burst_left--;
      req_bus.operation <= op;
      req_bus.sample    <= smp;
      req_bus.last      <= is_last;
      req_bus.valid     <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      meter.take_request(op, smp, is_last);
      @(negedge clock);
   endtask

   // drain: nothing pending, then room for a transaction that emits nothing
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (meter.pending_levels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(rmslm_pkg::csr_index_type idx,
                            logic [rmslm_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      meter.write_register(idx, data);
      @(negedge clock);
   endtask

   function automatic logic signed [rmslm_pkg::SAMPLE_W-1:0] pick_sample();
      logic signed [rmslm_pkg::SAMPLE_W-1:0] raw;
      raw = 16'($urandom);
      case ($urandom_range(0, 15))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return raw >>> $urandom_range(0, 14);
      endcase
   endfunction

   task automatic run_random(int unsigned n_items, bit full_first);
      int unsigned sent;
      int unsigned pick;
      int unsigned len;
      logic        end_flag;
      sent = 0;
      while (sent < n_items) begin
         pick = full_first ? 24 : $urandom_range(0, 199);
         full_first = 1'b0;
         if (pick < 24) begin
            send_item(rmslm_pkg::OP_POLL, 16'($urandom), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            // full block with no end marker, well-formed block, or a stray sample
            if (pick == 24)
               len = BLOCK_LEN;
            else if (pick < 176)
               len = $urandom_range(1, 12);
            else
               len = 1;
            for (int i = 0; i < len; i++) begin
               if (pick == 24)
                  end_flag = 1'b0;
               else if (pick < 176)
                  end_flag = (i == len - 1);
               else
                  end_flag = 1'($urandom_range(0, 1));
               send_item(rmslm_pkg::OP_SAMPLE, pick_sample(), end_flag);
            end
            sent += len;
         end
      end
   endtask

   initial begin
      logic [rmslm_pkg::GAIN_W-1:0] phase_gain;
      meter             = new();
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = rmslm_pkg::CSR_ATTEN_GAIN;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.operation = rmslm_pkg::OP_SAMPLE;
      req_bus.sample    = '0;
      req_bus.last      = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_csr(rmslm_pkg::CSR_ATTEN_GAIN, rmslm_pkg::GAIN_RESET);
      write_csr(rmslm_pkg::CSR_MIC_ENABLE, 16'd1);
      send_item(rmslm_pkg::OP_POLL,   16'h7FFF, 1'b1);
      send_item(rmslm_pkg::OP_SAMPLE, 16'h7FFF, 1'b1);
      send_item(rmslm_pkg::OP_SAMPLE, 16'h8000, 1'b1);
      send_item(rmslm_pkg::OP_POLL,   16'h0000, 1'b0);
      send_item(rmslm_pkg::OP_SAMPLE, 16'h0000, 1'b0);
      send_item(rmslm_pkg::OP_SAMPLE, 16'h0000, 1'b1);
      send_item(rmslm_pkg::OP_SAMPLE, -16'sd1,  1'b0);
      send_item(rmslm_pkg::OP_SAMPLE, 16'sd1,   1'b0);
      send_item(rmslm_pkg::OP_SAMPLE, 16'sd100, 1'b1);
      send_item(rmslm_pkg::OP_POLL,   16'h8000, 1'b1);

      // gain above unity saturates the scaled magnitude
      settle();
      write_csr(rmslm_pkg::CSR_ATTEN_GAIN, 16'hFFFF);
      send_item(rmslm_pkg::OP_SAMPLE, 16'h8000,   1'b1);
      send_item(rmslm_pkg::OP_SAMPLE, 16'sd20000, 1'b1);
      send_item(rmslm_pkg::OP_SAMPLE, 16'sd25000, 1'b0);

      settle();
      write_csr(rmslm_pkg::CSR_ATTEN_GAIN, 16'h0000);
      send_item(rmslm_pkg::OP_SAMPLE, 16'sd12345, 1'b1);
      send_item(rmslm_pkg::OP_SAMPLE, 16'sd777,   1'b0);

      // mic off: open block and level cleared, only zeros come back
      settle();
      write_csr(rmslm_pkg::CSR_MIC_ENABLE, 16'd0);
      write_csr(rmslm_pkg::CSR_ATTEN_GAIN, rmslm_pkg::GAIN_RESET);
      send_item(rmslm_pkg::OP_SAMPLE, 16'h7FFF, 1'b0);
      send_item(rmslm_pkg::OP_SAMPLE, 16'h8000, 1'b1);
      send_item(rmslm_pkg::OP_POLL,   16'h0000, 1'b0);

      settle();
      write_csr(rmslm_pkg::CSR_MIC_ENABLE, 16'd1);
      send_item(rmslm_pkg::OP_POLL,   16'h0000,  1'b0);
      send_item(rmslm_pkg::OP_SAMPLE, 16'sd3000, 1'b1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         case (p)
            0:       phase_gain = rmslm_pkg::GAIN_RESET;
            1:       phase_gain = 16'hFFFF;
            2:       phase_gain = 16'h0000;
            3:       phase_gain = 16'h4000;
            4:       phase_gain = 16'h0001;
            5:       phase_gain = 16'h7FFF;
            default: phase_gain = 16'($urandom_range(0, 65535));
         endcase
         write_csr(rmslm_pkg::CSR_ATTEN_GAIN, phase_gain);
         write_csr(rmslm_pkg::CSR_MIC_ENABLE, (p == 6) ? 16'd0 : 16'd1);
         run_random(PHASE_ITEMS, p == 0);
      end

      settle();
      if (meter.error_count == 0)
         $display("tb_rms_level_meter_attack_decay: clean");
      else
         $display("tb_rms_level_meter_attack_decay: errors");
      $finish;
   end

endmodule
